@@ hw/rtl/gcdb_pkg.sv @@
// Shared types, constants and tables for the great-circle distance/bearing pipeline.
// No dependencies.
package gcdb_pkg;

  localparam int CORDIC_STAGES = 24;
  localparam int CSTG = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
  localparam int CW = 36;                // CORDIC datapath width
  localparam int SQ_STEPS = 31;          // isqrt of a 61-bit value
  localparam int SQ_NW = 61;
  localparam int SQ_RW = 62;
  localparam int LAT = 2 * CSTG + 42;    // stages ahead of the output register

  localparam logic [30:0] RECIP45 = 31'd1527099484;  // ceil(2^36 / 45)
  localparam logic [15:0] RECIP45_S = 16'd46604;     // ceil(2^21 / 45)
  localparam logic signed [CW-1:0] INV_GAIN = 36'sd652032874;
  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  localparam logic [27:0] DIST_MAX = 28'd205887375;
  localparam logic [25:0] BEARING_TURN = 26'd23592960;
  localparam logic [15:0] RADIUS_RST = 16'd6371;

  typedef logic signed [CW-1:0] cword_t;
  typedef logic signed [32:0] q30_t;

  typedef struct packed {
    cword_t x;
    cword_t y;
    cword_t z;
  } cvec_t;

  // floor((512*r + 22) / 45) for r in 0..44
  function automatic logic [8:0] rem_angle(input logic [5:0] r);
    logic [14:0] n;
    logic [30:0] p;
    begin
      n = {r, 9'd0} + 15'd22;
      p = 31'(n) * 31'(RECIP45_S);
      rem_angle = p[29:21];
    end
  endfunction

  // round(atan(2^-i) * 2^31 / pi)
  function automatic logic [31:0] atan_val(input logic [4:0] i);
    begin
      case (i)
        5'd0: atan_val = 32'd536870912;
        5'd1: atan_val = 32'd316933406;
        5'd2: atan_val = 32'd167458907;
        5'd3: atan_val = 32'd85004756;
        5'd4: atan_val = 32'd42667331;
        5'd5: atan_val = 32'd21354465;
        5'd6: atan_val = 32'd10679838;
        5'd7: atan_val = 32'd5340245;
        5'd8: atan_val = 32'd2670163;
        5'd9: atan_val = 32'd1335087;
        5'd10: atan_val = 32'd667544;
        5'd11: atan_val = 32'd333772;
        5'd12: atan_val = 32'd166886;
        5'd13: atan_val = 32'd83443;
        5'd14: atan_val = 32'd41722;
        5'd15: atan_val = 32'd20861;
        5'd16: atan_val = 32'd10430;
        5'd17: atan_val = 32'd5215;
        5'd18: atan_val = 32'd2608;
        5'd19: atan_val = 32'd1304;
        5'd20: atan_val = 32'd652;
        5'd21: atan_val = 32'd326;
        5'd22: atan_val = 32'd163;
        5'd23: atan_val = 32'd81;
        5'd24: atan_val = 32'd41;
        5'd25: atan_val = 32'd20;
        5'd26: atan_val = 32'd10;
        5'd27: atan_val = 32'd5;
        5'd28: atan_val = 32'd3;
        5'd29: atan_val = 32'd1;
        5'd30: atan_val = 32'd1;
        5'd31: atan_val = 32'd0;
        default: atan_val = 32'd0;
      endcase
    end
  endfunction

endpackage

@@ hw/rtl/great_circle_distance_bearing_top.sv @@
// Throughput: one word per cycle; the rows of CORDIC and square-root cells are fully
// unrolled, so a new word enters every cycle while the output register can drain.
// Reset (rst_n low, synchronous): all stage valids and the output valid clear,
// sphere radius returns to 6371 km. Datapath registers are not reset.
// Depends on gcdb_pkg, gcdb_angle_conv, gcdb_cordic_cell, gcdb_sqrt_cell.
module great_circle_distance_bearing_top
  import gcdb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [27:0] in_start_lat,
  input  logic signed [28:0] in_start_lon,
  input  logic signed [27:0] in_end_lat,
  input  logic signed [28:0] in_end_lon,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [27:0]        out_distance_m,
  output logic [24:0]        out_bearing,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data
);

  logic en;
  logic [15:0] radius_r;
  logic [LAT-1:0] vld_r;
  logic out_valid_r;
  logic [27:0] dist_r, dist_nxt;
  logic [24:0] bear_r;

  assign en = ~out_valid_r | ~out_stall;
  assign in_stall = ~en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RST;
      vld_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        radius_r <= cfg_wr_data;
      end
      if (en) begin
        vld_r <= {vld_r[LAT-2:0], in_valid};
        out_valid_r <= vld_r[LAT-1];
      end
    end
  end

  // ---- angle conversion and sin/cos cell rows ----
  logic signed [29:0] ang_in [3];
  cword_t conv_z [3];
  logic   conv_flip [3];
  cvec_t  rot_c [3][CSTG+1];
  logic [CSTG-1:0] flip_sr_r [3];

  assign ang_in[0] = 30'(in_start_lat);
  assign ang_in[1] = 30'(in_end_lat);
  assign ang_in[2] = 30'(in_end_lon) - 30'(in_start_lon);

  for (genvar g = 0; g < 3; g++) begin : g_rot
    gcdb_angle_conv u_conv (
      .clk(clk), .en(en), .x_i(ang_in[g]), .z_o(conv_z[g]), .flip_o(conv_flip[g])
    );
    assign rot_c[g][0] = '{x: INV_GAIN, y: '0, z: conv_z[g]};
    for (genvar k = 0; k < CSTG; k++) begin : g_cell
      gcdb_cordic_cell u_cell (
        .clk(clk), .en(en), .vec_mode(1'b0), .shift(5'(k)), .atan(atan_val(5'(k))),
        .v_i(rot_c[g][k]), .v_o(rot_c[g][k+1])
      );
    end
    always_ff @(posedge clk) begin
      if (en) begin
        flip_sr_r[g] <= {flip_sr_r[g][CSTG-2:0], conv_flip[g]};
      end
    end
  end

  // ---- stage C: undo the half-turn fold ----
  q30_t sn_r [3], cs_r [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < 3; g++) begin
        sn_r[g] <= flip_sr_r[g][CSTG-1] ? 33'(-rot_c[g][CSTG].y) : 33'(rot_c[g][CSTG].y);
        cs_r[g] <= flip_sr_r[g][CSTG-1] ? 33'(-rot_c[g][CSTG].x) : 33'(rot_c[g][CSTG].x);
      end
    end
  end

  // ---- stage D: first products (0 = start, 1 = end, 2 = lon difference) ----
  logic signed [65:0] m_ss, m_cc, m_sc, m_cs, m_y;
  logic signed [63:0] p_ss_r, p_cs_r;
  logic signed [34:0] p_cc_r, p_sc_r, p_y_r;
  q30_t cd_d_r;

  always_comb begin
    m_ss = 66'(sn_r[0]) * 66'(sn_r[1]);
    m_cc = 66'(cs_r[0]) * 66'(cs_r[1]);
    m_sc = 66'(sn_r[0]) * 66'(cs_r[1]);
    m_cs = 66'(cs_r[0]) * 66'(sn_r[1]);
    m_y  = 66'(sn_r[2]) * 66'(cs_r[1]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_ss_r <= 64'(m_ss);
      p_cs_r <= 64'(m_cs);
      p_cc_r <= 35'(m_cc >>> 30);
      p_sc_r <= 35'(m_sc >>> 30);
      p_y_r <= 35'(m_y >>> 30);
      cd_d_r <= cs_r[2];
    end
  end

  // ---- stage E: products with cos of longitude difference ----
  logic signed [67:0] m_t1, m_t2;
  logic signed [63:0] t1_r, t2_r, p_ss_e_r, p_cs_e_r;
  logic signed [34:0] p_y_e_r;

  always_comb begin
    m_t1 = 68'(p_cc_r) * 68'(cd_d_r);
    m_t2 = 68'(p_sc_r) * 68'(cd_d_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r <= 64'(m_t1);
      t2_r <= 64'(m_t2);
      p_ss_e_r <= p_ss_r;
      p_cs_e_r <= p_cs_r;
      p_y_e_r <= p_y_r;
    end
  end

  // ---- stage F: central-angle cosine, bearing vector ----
  logic signed [64:0] sum_c, sum_x;
  logic signed [34:0] c_full;
  logic signed [31:0] c_nxt, c_f_r;
  logic signed [33:0] bx_nxt, by_nxt, bx_f_r, by_f_r;
  logic zero_nxt, zero_f_r;

  always_comb begin
    sum_c = 65'(p_ss_e_r) + 65'(t1_r);
    sum_x = 65'(p_cs_e_r) - 65'(t2_r);
    c_full = 35'(sum_c >>> 30);
    if (c_full > 35'sd1073741824) begin
      c_nxt = 32'sd1073741824;
    end else if (c_full < -35'sd1073741824) begin
      c_nxt = -32'sd1073741824;
    end else begin
      c_nxt = 32'(c_full);
    end
    bx_nxt = 34'(sum_x >>> 30);
    by_nxt = 34'(p_y_e_r);
    zero_nxt = (bx_nxt == '0) && (by_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_f_r <= c_nxt;
      bx_f_r <= bx_nxt;
      by_f_r <= by_nxt;
      zero_f_r <= zero_nxt;
    end
  end

  // ---- stage G: 1 - c^2 ----
  logic signed [63:0] cc_w;
  logic [SQ_NW-1:0] n0_r;
  logic signed [31:0] c_g_r;

  assign cc_w = 64'(c_f_r) * 64'(c_f_r);

  always_ff @(posedge clk) begin
    if (en) begin
      n0_r <= SQ_NW'(64'sh1000_0000_0000_0000 - cc_w);
      c_g_r <= c_f_r;
    end
  end

  // ---- square-root cell row, side data delayed alongside ----
  logic [SQ_NW-1:0] sq_n [SQ_STEPS+1];
  logic [SQ_RW-1:0] sq_r [SQ_STEPS+1];
  logic signed [31:0] c_sq_r [SQ_STEPS];
  logic signed [33:0] bx_sq_r [SQ_STEPS+1];
  logic signed [33:0] by_sq_r [SQ_STEPS+1];
  logic zero_sq_r [SQ_STEPS+1];

  assign sq_n[0] = n0_r;
  assign sq_r[0] = '0;

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
    gcdb_sqrt_cell u_sq (
      .clk(clk), .en(en), .step(5'(k)),
      .n_i(sq_n[k]), .r_i(sq_r[k]), .n_o(sq_n[k+1]), .r_o(sq_r[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_sq_r[0] <= c_g_r;
      bx_sq_r[0] <= bx_f_r;
      by_sq_r[0] <= by_f_r;
      zero_sq_r[0] <= zero_f_r;
      for (int k = 1; k < SQ_STEPS; k++) begin
        c_sq_r[k] <= c_sq_r[k-1];
      end
      for (int k = 1; k <= SQ_STEPS; k++) begin
        bx_sq_r[k] <= bx_sq_r[k-1];
        by_sq_r[k] <= by_sq_r[k-1];
        zero_sq_r[k] <= zero_sq_r[k-1];
      end
    end
  end

  // ---- stage H: fold into the right half plane, then vectoring cell rows ----
  cvec_t dv_c [CSTG+1];
  cvec_t bv_c [CSTG+1];
  cvec_t dv_h_r, bv_h_r;
  cword_t dx_w, dy_w, bx_w, by_w;
  logic [CSTG:0] zero_v_r;

  always_comb begin
    dx_w = CW'(c_sq_r[SQ_STEPS-1]);
    dy_w = CW'(sq_r[SQ_STEPS][30:0]);
    bx_w = CW'(bx_sq_r[SQ_STEPS]);
    by_w = CW'(by_sq_r[SQ_STEPS]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (dx_w[CW-1]) begin
        dv_h_r <= '{x: -dx_w, y: -dy_w, z: CW'(33'h0_8000_0000)};
      end else begin
        dv_h_r <= '{x: dx_w, y: dy_w, z: '0};
      end
      if (bx_w[CW-1]) begin
        bv_h_r <= '{x: -bx_w, y: -by_w, z: CW'(33'h0_8000_0000)};
      end else begin
        bv_h_r <= '{x: bx_w, y: by_w, z: '0};
      end
      zero_v_r <= {zero_v_r[CSTG-1:0], zero_sq_r[SQ_STEPS]};
    end
  end

  assign dv_c[0] = dv_h_r;
  assign bv_c[0] = bv_h_r;

  for (genvar k = 0; k < CSTG; k++) begin : g_vec
    gcdb_cordic_cell u_dcell (
      .clk(clk), .en(en), .vec_mode(1'b1), .shift(5'(k)), .atan(atan_val(5'(k))),
      .v_i(dv_c[k]), .v_o(dv_c[k+1])
    );
    gcdb_cordic_cell u_bcell (
      .clk(clk), .en(en), .vec_mode(1'b1), .shift(5'(k)), .atan(atan_val(5'(k))),
      .v_i(bv_c[k]), .v_o(bv_c[k+1])
    );
  end

  // ---- stage I: clamp angle and scale by radius; bearing to 2^-16 degree ----
  cword_t za;
  logic [31:0] ang_w, ba_w;
  logic [47:0] m1_r;
  logic [38:0] b45;
  logic [25:0] b26;
  logic [24:0] b_nxt, b_i_r, b_j_r, b_k_r;

  always_comb begin
    za = dv_c[CSTG].z;
    if (za[CW-1]) begin
      ang_w = '0;
    end else if (za > CW'(33'h0_8000_0000)) begin
      ang_w = 32'h8000_0000;
    end else begin
      ang_w = za[31:0];
    end
    ba_w = bv_c[CSTG].z[31:0];
    b45 = 39'(ba_w) * 39'd45 + 39'd4096;
    b26 = b45[38:13];
    if (zero_v_r[CSTG]) begin
      b_nxt = '0;
    end else if (b26 >= BEARING_TURN) begin
      b_nxt = 25'(b26 - BEARING_TURN);
    end else begin
      b_nxt = 25'(b26);
    end
  end

  // ---- stages J, K: meters and times pi ----
  logic [57:0] v_r;
  logic [57:0] hi_r;
  logic [31:0] lo_r;
  logic [63:0] lo_full;

  assign lo_full = 64'(v_r[31:0]) * 64'(PI_Q30);

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r <= 48'(ang_w) * 48'(radius_r);
      b_i_r <= b_nxt;
      v_r <= 58'(m1_r) * 58'd1000;
      b_j_r <= b_i_r;
      hi_r <= 58'(v_r[57:32]) * 58'(PI_Q30);
      lo_r <= lo_full[63:32];
      b_k_r <= b_j_r;
    end
  end

  // ---- output register ----
  logic [58:0] acc_w;
  logic [29:0] dq_w;

  always_comb begin
    acc_w = 59'(hi_r) + 59'(lo_r) + 59'h1000_0000;
    dq_w = acc_w[58:29];
    dist_nxt = (dq_w > 30'(DIST_MAX)) ? DIST_MAX : dq_w[27:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dist_r <= dist_nxt;
      bear_r <= b_k_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_distance_m = dist_r;
  assign out_bearing = bear_r;

endmodule

@@ hw/rtl/gcdb_angle_conv.sv @@
// Two-stage conversion of a 2^-20 degree value to a binary angle, folded for CORDIC.
// Depends on gcdb_pkg.
module gcdb_angle_conv
  import gcdb_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic signed [29:0] x_i,
  output cword_t             z_o,
  output logic               flip_o
);

  logic        neg_r, neg_nxt;
  logic [28:0] mag_r, mag_nxt;
  logic [23:0] quo_r, quo_nxt;
  logic [59:0] prod;
  logic [29:0] rem_w;
  logic [32:0] q_w;
  logic [31:0] ang_w, ang2_w;
  logic        flip_nxt;
  cword_t      z_nxt;
  cword_t      z_r;
  logic        flip_r;

  // |x| / 45 by reciprocal; exact for |x| < 2^29
  always_comb begin
    neg_nxt = x_i[29];
    mag_nxt = neg_nxt ? 29'(-x_i) : 29'(x_i);
    prod = 60'(mag_nxt) * 60'(RECIP45);
    quo_nxt = prod[59:36];
  end

  always_comb begin
    rem_w = 30'(mag_r) - 30'(quo_r) * 30'd45;
    q_w = {quo_r, 9'd0} + 33'(rem_angle(rem_w[5:0]));
    ang_w = neg_r ? -q_w[31:0] : q_w[31:0];
    flip_nxt = ang_w[31] ^ ang_w[30];   // second or third quadrant
    ang2_w = flip_nxt ? ang_w + 32'h8000_0000 : ang_w;
    z_nxt = CW'($signed(ang2_w));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r <= neg_nxt;
      mag_r <= mag_nxt;
      quo_r <= quo_nxt;
      z_r <= z_nxt;
      flip_r <= flip_nxt;
    end
  end

  assign z_o = z_r;
  assign flip_o = flip_r;

endmodule

@@ hw/rtl/gcdb_cordic_cell.sv @@
// One registered CORDIC micro-rotation, rotation or vectoring mode.
// Depends on gcdb_pkg.
module gcdb_cordic_cell
  import gcdb_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic        vec_mode,
  input  logic [4:0]  shift,
  input  logic [31:0] atan,
  input  cvec_t       v_i,
  output cvec_t       v_o
);

  cvec_t  v_r, v_nxt;
  cword_t dx, dy;
  logic   dir_neg;

  always_comb begin
    dx = v_i.y >>> shift;
    dy = v_i.x >>> shift;
    dir_neg = vec_mode ? v_i.y[CW-1] : ~v_i.z[CW-1];
    if (dir_neg) begin
      v_nxt.x = v_i.x - dx;
      v_nxt.y = v_i.y + dy;
      v_nxt.z = v_i.z - CW'(atan);
    end else begin
      v_nxt.x = v_i.x + dx;
      v_nxt.y = v_i.y - dy;
      v_nxt.z = v_i.z + CW'(atan);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r <= v_nxt;
    end
  end

  assign v_o = v_r;

endmodule

@@ hw/rtl/gcdb_sqrt_cell.sv @@
// One registered digit step of a restoring integer square root.
// Depends on gcdb_pkg.
module gcdb_sqrt_cell
  import gcdb_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [4:0]       step,
  input  logic [SQ_NW-1:0] n_i,
  input  logic [SQ_RW-1:0] r_i,
  output logic [SQ_NW-1:0] n_o,
  output logic [SQ_RW-1:0] r_o
);

  logic [SQ_NW-1:0] n_r, n_nxt;
  logic [SQ_RW-1:0] r_r, r_nxt;
  logic [5:0]       sh;
  logic [SQ_RW-1:0] bit_w, trial;

  always_comb begin
    sh = 6'd60 - {step, 1'b0};
    bit_w = SQ_RW'(1) << sh;
    trial = r_i + bit_w;
    if (SQ_RW'(n_i) >= trial) begin
      n_nxt = n_i - SQ_NW'(trial);
      r_nxt = (r_i >> 1) + bit_w;
    end else begin
      n_nxt = n_i;
      r_nxt = r_i >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r <= n_nxt;
      r_r <= r_nxt;
    end
  end

  assign n_o = n_r;
  assign r_o = r_r;

endmodule

@@ hw/rtl/gcdb_checker.sv @@
// Port-level checks for great_circle_distance_bearing_top, bound to the top level.
// Depends on the top level's ports only.
module gcdb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [27:0] out_distance_m,
  input logic [24:0] out_bearing
);

  // output word holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> ($stable(out_distance_m) && $stable(out_bearing)))
    else $error("output word changed while stalled");

  // input only back-pressured by a full, stalled output register
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled with room in pipeline");

  a_bear_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_bearing < 25'd23592960))
    else $error("bearing out of range");

  a_dist_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_distance_m <= 28'd205887375))
    else $error("distance above saturation");

endmodule

bind great_circle_distance_bearing_top gcdb_checker u_gcdb_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_distance_m(out_distance_m),
  .out_bearing(out_bearing)
);

@@ test/tb_great_circle_distance_bearing_top.sv @@
// Self-checking bench for great_circle_distance_bearing_top: directed and random position
// pairs with random idling on both channels, checked against a bit-exact CORDIC predictor.
// Depends on gcdb_pkg and the block's RTL.
module tb_great_circle_distance_bearing_top;
  import gcdb_pkg::*;

  localparam int NSTG = CSTG;
  localparam int PIPE_WAIT = 2 * NSTG + 60;
  localparam int CYCLE_LIMIT = 900000;
  localparam longint LAT_MAX = 94371840;
  localparam longint LON_MAX = 188743680;

  typedef struct {
    logic [27:0] dist_m;
    logic [24:0] bear;
  } route_t;

  class route_board;
    route_t pending[$];
    longint unsigned radius_km;
    int errors;
    longint atan_lut[32];

    function new();
      atan_lut = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                   10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
                   41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
                   10, 5, 3, 1, 1, 0};
      radius_km = 6371;
      errors = 0;
    endfunction

    function bit [31:0] deg_to_bam(longint xv);
      longint unsigned m, q;
      m = longint'(xv < 0 ? -xv : xv) * 512;
      q = (m + 22) / 45;
      if (xv < 0) q = -q;
      return q[31:0];
    endfunction

    function void rotate(bit [31:0] a, output longint sn, output longint cs);
      bit flip;
      longint x, y, z, dx, dy;
      flip = a[31] ^ a[30];
      if (flip) a = a + 32'h8000_0000;
      x = 652032874;
      y = 0;
      z = longint'($signed(a));
      for (int i = 0; i < NSTG; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_lut[i];
        end else begin
          x += dx; y -= dy; z += atan_lut[i];
        end
      end
      sn = flip ? -y : y;
      cs = flip ? -x : x;
    endfunction

    function longint heading(longint y, longint x);
      longint z, dx, dy;
      z = 0;
      if (x < 0) begin
        x = -x; y = -y; z = 64'sd2147483648;
      end
      for (int i = 0; i < NSTG; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y < 0) begin
          x -= dx; y += dy; z -= atan_lut[i];
        end else begin
          x += dx; y -= dy; z += atan_lut[i];
        end
      end
      return z;
    endfunction

    function longint unsigned root(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b;
          r = (r >> 1) + b;
        end else r >>= 1;
        b >>= 2;
      end
      return r;
    endfunction

    function void note_word(longint la1, longint lo1, longint la2, longint lo2);
      longint s1, c1, s2, c2, sd, cd, c, ang, bx, by;
      longint unsigned s, v, vh, vl, acc, d, b;
      bit [31:0] ba;
      route_t r;
      rotate(deg_to_bam(la1), s1, c1);
      rotate(deg_to_bam(la2), s2, c2);
      rotate(deg_to_bam(lo2 - lo1), sd, cd);
      c = (s1 * s2 + ((c1 * c2) >>> 30) * cd) >>> 30;
      if (c > 64'sd1073741824) c = 64'sd1073741824;
      if (c < -64'sd1073741824) c = -64'sd1073741824;
      s = root((64'd1 << 60) - longint'(c * c));
      ang = heading(longint'(s), c);
      if (ang < 0) ang = 0;
      if (ang > 64'sd2147483648) ang = 64'sd2147483648;
      v = longint'(ang) * radius_km * 1000;
      vh = v >> 32;
      vl = v & 64'hFFFF_FFFF;
      acc = vh * 64'd3373259426 + ((vl * 64'd3373259426) >> 32);
      d = (acc + (64'd1 << 28)) >> 29;
      if (d > 205887375) d = 205887375;
      by = (sd * c2) >>> 30;
      bx = (c1 * s2 - ((s1 * c2) >>> 30) * cd) >>> 30;
      if (bx == 0 && by == 0) b = 0;
      else begin
        ba = 32'(heading(by, bx));
        b = (longint'(ba) * 45 + 4096) >> 13;
        if (b >= 23592960) b -= 23592960;
      end
      r.dist_m = d[27:0];
      r.bear = b[24:0];
      pending.push_back(r);
    endfunction

    function void check_word(logic [27:0] dist_m, logic [24:0] bear);
      route_t r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected output word dist %0d bearing %0d", $time, dist_m, bear);
        errors++;
        return;
      end
      r = pending.pop_front();
      if (dist_m !== r.dist_m) begin
        $display("%0t: distance expected %0d actual %0d", $time, r.dist_m, dist_m);
        errors++;
      end
      if (bear !== r.bear) begin
        $display("%0t: bearing expected %0d actual %0d", $time, r.bear, bear);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [27:0] in_start_lat = 0;
  logic signed [28:0] in_start_lon = 0;
  logic signed [27:0] in_end_lat = 0;
  logic signed [28:0] in_end_lon = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [27:0] out_distance_m;
  logic [24:0] out_bearing;
  logic cfg_wr_en = 0;
  logic [15:0] cfg_wr_data = 0;

  route_board board = new();
  bit calm = 0;
  int cycles = 0;

  great_circle_distance_bearing_top uut (.*);

  initial forever #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_word(out_distance_m, out_bearing);
    out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 24);
  end

  task automatic send_pos(longint la1, longint lo1, longint la2, longint lo2);
    if (!calm && $urandom_range(0, 99) < 31) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_start_lat <= la1[27:0];
    in_start_lon <= lo1[28:0];
    in_end_lat <= la2[27:0];
    in_end_lon <= lo2[28:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_word($signed(la1[27:0]), $signed(lo1[28:0]),
                    $signed(la2[27:0]), $signed(lo2[28:0]));
  endtask

  // drain, then let the pipe empty before touching the radius
  task automatic set_radius(logic [15:0] r);
    in_valid <= 0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (PIPE_WAIT) @(posedge clk);
    cfg_wr_en <= 1;
    cfg_wr_data <= r;
    @(posedge clk);
    cfg_wr_en <= 0;
    board.radius_km = r;
  endtask

  function automatic longint pick(longint lim);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 8) return longint'($signed($urandom())) >>> 3;  // full field range
    if (sel < 14) return (sel & 1) ? lim : -lim;
    return longint'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  initial begin
    longint la, lo;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: extremes, coincident, poles, antipodes, out of range
    send_pos(0, 0, 0, 0);
    send_pos(LAT_MAX, 0, -LAT_MAX, 0);
    send_pos(-LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX);
    send_pos(LAT_MAX, 12345, LAT_MAX, -998877);
    send_pos(0, 0, 0, LON_MAX);
    send_pos(0, -LON_MAX, 0, LON_MAX);
    send_pos(40000000, 5000000, 40000000, 5000000);
    send_pos(-134217728, -268435456, 134217727, 268435455);
    send_pos(134217727, 268435455, -134217728, -268435456);
    send_pos(0, 0, 1, 0);
    send_pos(0, 0, 0, 1);
    send_pos(0, 0, -1, -1);
    send_pos(20000000, 30000000, -20000000, 30000000 - LON_MAX);
    send_pos(LAT_MAX, 0, 0, 0);
    send_pos(0, 0, LAT_MAX / 2, LON_MAX / 2);
    set_radius(16'd1);
    send_pos(0, 0, 0, LON_MAX);
    send_pos(LAT_MAX, 0, -LAT_MAX, 0);
    set_radius(16'd65535);
    send_pos(0, 0, 0, LON_MAX);
    send_pos(LAT_MAX, 0, -LAT_MAX, 0);
    send_pos(10000000, 0, -30000000, 150000000);
    set_radius(16'd0);
    send_pos(0, 0, 0, LON_MAX);
    send_pos(1000000, 2000000, 3000000, 4000000);
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_radius(16'd6371);
        1: set_radius(16'd65535);
        2: set_radius(16'd1);
        default: set_radius($urandom_range(1, 65535));
      endcase
      for (int k = 0; k < 230; k++) begin
        calm = (ph == 1 && k >= 40 && k < 200);
        la = pick(LAT_MAX);
        lo = pick(LON_MAX);
        if ($urandom_range(0, 9) == 0) send_pos(la, lo, la, lo);
        else send_pos(la, lo, pick(LAT_MAX), pick(LON_MAX));
      end
      calm = 0;
    end
    in_valid <= 0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (PIPE_WAIT) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule

@@ filelist.f @@
hw/rtl/gcdb_pkg.sv
hw/rtl/gcdb_angle_conv.sv
hw/rtl/gcdb_cordic_cell.sv
hw/rtl/gcdb_sqrt_cell.sv
hw/rtl/great_circle_distance_bearing_top.sv
hw/rtl/gcdb_checker.sv
test/tb_great_circle_distance_bearing_top.sv
